>>> rtl/rcp_pkg.sv
// Shared types, widths and constants of the ray cube picking block.
// Used by rcp_front, rcp_back, ray_cube_pick_nearest and the testbench; depends on nothing.
`default_nettype none
package rcp_pkg;

    localparam int COORD_W = 24;
    localparam int LEN_W   = 23;
    localparam int DIST_W  = 25;
    localparam int IDXO_W  = 6;
    localparam int U_W     = 25;
    localparam int DS_W    = 26;
    localparam int N_W     = 27;
    localparam int MUL_W   = 27;
    localparam int PROD_W  = 54;
    localparam int T_W     = 55;
    localparam int NUM_W   = 53;
    localparam int DEN_W   = 26;
    localparam int Q_W     = 25;
    localparam int SQ_W    = 52;
    localparam int CFG_IDX_W = 3;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_START_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_END_X   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_END_Y   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_END_Z   = 3'd5;

    typedef struct packed {
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        logic signed [COORD_W-1:0] sz;
        logic signed [COORD_W-1:0] ex;
        logic signed [COORD_W-1:0] ey;
        logic signed [COORD_W-1:0] ez;
    } ray_t;

    // One queued cube: doubled offsets 2*(S - C), edge length and end mark.
    typedef struct packed {
        logic signed [DS_W-1:0] ds_x;
        logic signed [DS_W-1:0] ds_y;
        logic signed [DS_W-1:0] ds_z;
        logic [LEN_W-1:0]       len;
        logic                   last;
    } cube_t;

    typedef struct packed {
        logic                hit;
        logic [IDXO_W-1:0]   index;
        logic [DIST_W-1:0]   distance;
    } result_t;

endpackage
`default_nettype wire

>>> rtl/ray_cube_pick_nearest.sv
// Top level of the nearest-cube picking block: configuration registers,
// front and back ends and the result register. Depends on rcp_pkg,
// rcp_front and rcp_back.
//
//   Channel   Handshake               Payload
//   cubes     push / full             center_x/y/z, edge_length, last_cube
//   results   pop / empty             hit_found, nearest_index, nearest_distance
//   config    cfg_write (no wait)     cfg_index, cfg_data
//
// A cube is taken in the idle state and finished in the done state; in between
// the back end runs its six faces in turn unless MAX_CUBES cubes came before it.
// A face that hits runs three 25-step serial divisions and a 26-step serial
// square root (an offset that saturates skips its division, and any saturation
// skips the square root). A face on an axis with no ray component is skipped.
// Reset empties the queue and result register, resets the nearest-cube state
// and zeroes the ray. The front queue holds two cubes, so cubes are taken
// while the back end works or while a result waits to be popped.
`default_nettype none
module ray_cube_pick_nearest #(
    parameter int MAX_CUBES = 64
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write,
    input  wire logic [rcp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [rcp_pkg::COORD_W-1:0]         cfg_data,
    input  wire logic                                push,
    output logic                                     full,
    input  wire logic signed [rcp_pkg::COORD_W-1:0]  center_x,
    input  wire logic signed [rcp_pkg::COORD_W-1:0]  center_y,
    input  wire logic signed [rcp_pkg::COORD_W-1:0]  center_z,
    input  wire logic [rcp_pkg::LEN_W-1:0]           edge_length,
    input  wire logic                                last_cube,
    output logic                                     empty,
    input  wire logic                                pop,
    output logic                                     hit_found,
    output logic [rcp_pkg::IDXO_W-1:0]               nearest_index,
    output logic [rcp_pkg::DIST_W-1:0]               nearest_distance
);

    rcp_pkg::ray_t    ray_reg, ray_next;
    rcp_pkg::cube_t   q_data;
    logic             q_valid, q_take;
    rcp_pkg::result_t res, out_reg;
    logic             res_valid, res_ready;
    logic             out_valid_reg, out_valid_next;

    // Ray registers; an index beyond the list is ignored.
    always_comb
    begin
        ray_next = ray_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                rcp_pkg::CFG_START_X: ray_next.sx = cfg_data;
                rcp_pkg::CFG_START_Y: ray_next.sy = cfg_data;
                rcp_pkg::CFG_START_Z: ray_next.sz = cfg_data;
                rcp_pkg::CFG_END_X:   ray_next.ex = cfg_data;
                rcp_pkg::CFG_END_Y:   ray_next.ey = cfg_data;
                rcp_pkg::CFG_END_Z:   ray_next.ez = cfg_data;
                default:              ray_next = ray_reg;
            endcase
        end
    end

    rcp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .ray         (ray_reg),
        .push        (push),
        .full        (full),
        .center_x    (center_x),
        .center_y    (center_y),
        .center_z    (center_z),
        .edge_length (edge_length),
        .last_cube   (last_cube),
        .q_valid     (q_valid),
        .q_take      (q_take),
        .q_data      (q_data)
    );

    rcp_back #(
        .MAX_CUBES (MAX_CUBES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .ray       (ray_reg),
        .q_valid   (q_valid),
        .q_take    (q_take),
        .q_data    (q_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // The result register frees itself in the same cycle that it is popped.
    assign res_ready = !out_valid_reg || pop;
    assign empty     = !out_valid_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign hit_found        = out_reg.hit;
    assign nearest_index    = out_reg.index;
    assign nearest_distance = out_reg.distance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ray_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ray_reg       <= ray_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

endmodule
`default_nettype wire

>>> rtl/rcp_front.sv
// Front end: accepts cubes, forms the doubled start offsets and queues them.
// Depends on rcp_pkg.
`default_nettype none
module rcp_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire rcp_pkg::ray_t                 ray,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic signed [rcp_pkg::COORD_W-1:0] center_x,
    input  wire logic signed [rcp_pkg::COORD_W-1:0] center_y,
    input  wire logic signed [rcp_pkg::COORD_W-1:0] center_z,
    input  wire logic [rcp_pkg::LEN_W-1:0]     edge_length,
    input  wire logic                          last_cube,
    output logic                               q_valid,
    input  wire logic                          q_take,
    output rcp_pkg::cube_t                     q_data
);

    rcp_pkg::cube_t entry_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    rcp_pkg::cube_t in_cube;
    logic           do_push, do_pop;

    function automatic logic signed [rcp_pkg::DS_W-1:0] dbl_diff(
        input logic signed [rcp_pkg::COORD_W-1:0] s,
        input logic signed [rcp_pkg::COORD_W-1:0] c);
        logic signed [rcp_pkg::COORD_W:0] d;
        begin
            d = {s[rcp_pkg::COORD_W-1], s} - {c[rcp_pkg::COORD_W-1], c};
            dbl_diff = {d, 1'b0};
        end
    endfunction

    always_comb
    begin
        in_cube.ds_x = dbl_diff(ray.sx, center_x);
        in_cube.ds_y = dbl_diff(ray.sy, center_y);
        in_cube.ds_z = dbl_diff(ray.sz, center_z);
        in_cube.len  = edge_length;
        in_cube.last = last_cube;
    end

    assign full    = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_data  = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = q_take && q_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= in_cube;
        end
    end

endmodule
`default_nettype wire

>>> rtl/rcp_back.sv
// Back end: face-by-face intersection sequencer with a shared multiplier,
// a bit-serial divider and a bit-serial square root; keeps the nearest cube.
// Depends on rcp_pkg.
`default_nettype none
module rcp_back #(
    parameter int MAX_CUBES = 64
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire rcp_pkg::ray_t  ray,
    input  wire logic           q_valid,
    output logic                q_take,
    input  wire rcp_pkg::cube_t q_data,
    output logic                res_valid,
    input  wire logic           res_ready,
    output rcp_pkg::result_t    res
);

    localparam int CNT_W = $clog2(MAX_CUBES + 1);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SETUP  = 4'd1;
    localparam logic [3:0] ST_MUL    = 4'd2;
    localparam logic [3:0] ST_CHECK  = 4'd3;
    localparam logic [3:0] ST_DIVSAT = 4'd4;
    localparam logic [3:0] ST_DIV    = 4'd5;
    localparam logic [3:0] ST_SQMUL  = 4'd6;
    localparam logic [3:0] ST_SQADD  = 4'd7;
    localparam logic [3:0] ST_SQRT   = 4'd8;
    localparam logic [3:0] ST_RESULT = 4'd9;
    localparam logic [3:0] ST_FACE   = 4'd10;
    localparam logic [3:0] ST_DONE   = 4'd11;

    logic [3:0] state_reg, state_next;
    logic [2:0] face_reg, face_next;
    logic [3:0] mstep_reg, mstep_next;
    logic [1:0] k_reg, k_next;
    logic [4:0] iter_reg, iter_next;

    logic signed [rcp_pkg::U_W-1:0]  ux_reg, uy_reg, uz_reg;
    logic signed [rcp_pkg::U_W-1:0]  ux_next, uy_next, uz_next;
    rcp_pkg::cube_t                  cube_reg, cube_next;
    logic signed [rcp_pkg::N_W-1:0]  n_reg, n_next;
    logic signed [rcp_pkg::PROD_W-1:0] prod_reg;
    logic [rcp_pkg::PROD_W-1:0]      lim_reg, lim_next;
    logic signed [rcp_pkg::T_W-1:0]  t1_reg, t1_next, t2_reg, t2_next;
    logic signed [rcp_pkg::PROD_W-1:0] num_reg [3];
    logic signed [rcp_pkg::PROD_W-1:0] num_next [3];
    logic                            sat_reg, sat_next;
    logic [rcp_pkg::SQ_W-1:0]        sq_reg, sq_next;
    logic [rcp_pkg::NUM_W-1:0]       rem_reg, rem_next, dsh_reg, dsh_next;
    logic [rcp_pkg::Q_W-1:0]         q_reg, q_next;
    logic [rcp_pkg::SQ_W-1:0]        v_reg, v_next, r_reg, r_next, b_reg, b_next;
    logic                            chit_reg, chit_next;
    logic [rcp_pkg::DIST_W-1:0]      cbest_reg, cbest_next;

    logic [rcp_pkg::DIST_W-1:0]      best_reg, best_next;
    logic [CNT_W-1:0]                bidx_reg, bidx_next;
    logic                            any_reg, any_next;
    logic [CNT_W-1:0]                cnt_reg, cnt_next;

    logic signed [rcp_pkg::MUL_W-1:0] ma, mb;
    logic [1:0]                      axis;
    logic                            side;
    logic signed [rcp_pkg::U_W-1:0]  ua, ub1, ub2, uk;
    logic signed [rcp_pkg::DS_W-1:0] dsa, dsb1, dsb2;
    logic [rcp_pkg::DEN_W-1:0]       ua_abs;
    logic [rcp_pkg::DEN_W-1:0]       den;
    logic [rcp_pkg::NUM_W-1:0]       num_abs;
    logic [rcp_pkg::PROD_W-1:0]      t1_abs, t2_abs;
    logic [rcp_pkg::SQ_W-1:0]        rb_sum;
    logic [rcp_pkg::DIST_W-1:0]      face_d;
    logic [rcp_pkg::DIST_W-1:0]      cube_d;
    logic                            upd_any;
    logic [CNT_W-1:0]                upd_idx;
    logic [rcp_pkg::DIST_W-1:0]      upd_best;
    logic [CNT_W+rcp_pkg::IDXO_W-1:0] idx_ext;
    logic                            cnt_ok;
    logic signed [rcp_pkg::N_W-1:0]  len_s;

    function automatic logic signed [rcp_pkg::U_W-1:0] sel_u(input logic [1:0] i,
        input logic signed [rcp_pkg::U_W-1:0] x, input logic signed [rcp_pkg::U_W-1:0] y,
        input logic signed [rcp_pkg::U_W-1:0] z);
        begin
            case (i)
                2'd0:    sel_u = x;
                2'd1:    sel_u = y;
                default: sel_u = z;
            endcase
        end
    endfunction

    function automatic logic signed [rcp_pkg::DS_W-1:0] sel_ds(input logic [1:0] i,
        input logic signed [rcp_pkg::DS_W-1:0] x, input logic signed [rcp_pkg::DS_W-1:0] y,
        input logic signed [rcp_pkg::DS_W-1:0] z);
        begin
            case (i)
                2'd0:    sel_ds = x;
                2'd1:    sel_ds = y;
                default: sel_ds = z;
            endcase
        end
    endfunction

    function automatic logic [rcp_pkg::PROD_W-1:0] abs_t(
        input logic signed [rcp_pkg::T_W-1:0] v);
        logic signed [rcp_pkg::T_W-1:0] m;
        begin
            m = (v < 0) ? -v : v;
            abs_t = m[rcp_pkg::PROD_W-1:0];
        end
    endfunction

    function automatic logic [rcp_pkg::DEN_W-1:0] DEN_FROM(
        input logic signed [rcp_pkg::U_W:0] v);
        begin
            DEN_FROM = v[rcp_pkg::DEN_W-1:0];
        end
    endfunction

    function automatic logic [rcp_pkg::NUM_W-1:0] NUM_FROM(
        input logic signed [rcp_pkg::PROD_W-1:0] v);
        begin
            NUM_FROM = v[rcp_pkg::NUM_W-1:0];
        end
    endfunction

    always_comb
    begin
        axis   = face_reg[2:1];
        side   = face_reg[0];
        ua     = sel_u(axis, ux_reg, uy_reg, uz_reg);
        ub1    = sel_u((axis == 2'd0) ? 2'd1 : 2'd0, ux_reg, uy_reg, uz_reg);
        ub2    = sel_u((axis == 2'd2) ? 2'd1 : 2'd2, ux_reg, uy_reg, uz_reg);
        uk     = sel_u(mstep_reg[1:0] - 2'd1, ux_reg, uy_reg, uz_reg);
        dsa    = sel_ds(axis, cube_reg.ds_x, cube_reg.ds_y, cube_reg.ds_z);
        dsb1   = sel_ds((axis == 2'd0) ? 2'd1 : 2'd0, cube_reg.ds_x, cube_reg.ds_y,
                        cube_reg.ds_z);
        dsb2   = sel_ds((axis == 2'd2) ? 2'd1 : 2'd2, cube_reg.ds_x, cube_reg.ds_y,
                        cube_reg.ds_z);
        ua_abs = (ua < 0) ? DEN_FROM(-{ua[rcp_pkg::U_W-1], ua})
                          : DEN_FROM({ua[rcp_pkg::U_W-1], ua});
        den    = {ua_abs[rcp_pkg::DEN_W-2:0], 1'b0};
        num_abs = (num_reg[k_reg] < 0) ? NUM_FROM(-num_reg[k_reg]) : NUM_FROM(num_reg[k_reg]);
        t1_abs = abs_t(t1_reg);
        t2_abs = abs_t(t2_reg);
        rb_sum = r_reg + b_reg;
        len_s  = {4'b0, cube_reg.len};
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        ma = '0;
        mb = '0;
        if (state_reg == ST_SQMUL)
        begin
            ma = {2'b0, q_reg};
            mb = {2'b0, q_reg};
        end
        else
        begin
            case (mstep_reg)
                4'd0:
                begin
                    ma = len_s;
                    mb = {1'b0, ua_abs};
                end
                4'd1:
                begin
                    ma = {dsb1[rcp_pkg::DS_W-1], dsb1};
                    mb = {{2{ua[rcp_pkg::U_W-1]}}, ua};
                end
                4'd2:
                begin
                    ma = {{2{ub1[rcp_pkg::U_W-1]}}, ub1};
                    mb = n_reg;
                end
                4'd3:
                begin
                    ma = {dsb2[rcp_pkg::DS_W-1], dsb2};
                    mb = {{2{ua[rcp_pkg::U_W-1]}}, ua};
                end
                4'd4:
                begin
                    ma = {{2{ub2[rcp_pkg::U_W-1]}}, ub2};
                    mb = n_reg;
                end
                4'd5, 4'd6, 4'd7:
                begin
                    ma = {{2{uk[rcp_pkg::U_W-1]}}, uk};
                    mb = n_reg;
                end
                default:
                begin
                    ma = '0;
                    mb = '0;
                end
            endcase
        end
    end

    always_comb
    begin
        face_d = sat_reg ? rcp_pkg::DIST_MAX :
                 ((r_reg > {{(rcp_pkg::SQ_W-rcp_pkg::DIST_W){1'b0}}, rcp_pkg::DIST_MAX})
                  ? rcp_pkg::DIST_MAX : r_reg[rcp_pkg::DIST_W-1:0]);
        cube_d = chit_reg ? cbest_reg : '0;
        cnt_ok = (cnt_reg < CNT_W'(MAX_CUBES));
        upd_any  = any_reg;
        upd_idx  = bidx_reg;
        upd_best = best_reg;
        if (cnt_ok && (cube_d != '0) && (!any_reg || (cube_d < best_reg)))
        begin
            upd_any  = 1'b1;
            upd_idx  = cnt_reg;
            upd_best = cube_d;
        end
        idx_ext      = {{rcp_pkg::IDXO_W{1'b0}}, upd_idx};
        res.hit      = upd_any;
        res.index    = upd_any ? idx_ext[rcp_pkg::IDXO_W-1:0] : '0;
        res.distance = upd_any ? upd_best : '0;
        res_valid    = (state_reg == ST_DONE) && cube_reg.last;
        q_take       = (state_reg == ST_IDLE);
    end

    always_comb
    begin
        state_next = state_reg;
        face_next  = face_reg;
        mstep_next = mstep_reg;
        k_next     = k_reg;
        iter_next  = iter_reg;
        ux_next    = ux_reg;
        uy_next    = uy_reg;
        uz_next    = uz_reg;
        cube_next  = cube_reg;
        n_next     = n_reg;
        lim_next   = lim_reg;
        t1_next    = t1_reg;
        t2_next    = t2_reg;
        num_next   = num_reg;
        sat_next   = sat_reg;
        sq_next    = sq_reg;
        rem_next   = rem_reg;
        dsh_next   = dsh_reg;
        q_next     = q_reg;
        v_next     = v_reg;
        r_next     = r_reg;
        b_next     = b_reg;
        chit_next  = chit_reg;
        cbest_next = cbest_reg;
        best_next  = best_reg;
        bidx_next  = bidx_reg;
        any_next   = any_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    cube_next = q_data;
                    ux_next = {ray.ex[rcp_pkg::COORD_W-1], ray.ex} -
                              {ray.sx[rcp_pkg::COORD_W-1], ray.sx};
                    uy_next = {ray.ey[rcp_pkg::COORD_W-1], ray.ey} -
                              {ray.sy[rcp_pkg::COORD_W-1], ray.sy};
                    uz_next = {ray.ez[rcp_pkg::COORD_W-1], ray.ez} -
                              {ray.sz[rcp_pkg::COORD_W-1], ray.sz};
                    face_next  = 3'd0;
                    chit_next  = 1'b0;
                    state_next = cnt_ok ? ST_SETUP : ST_DONE;
                end
            end
            ST_SETUP:
            begin
                if (ua == '0)
                begin
                    state_next = ST_FACE;
                end
                else
                begin
                    n_next = (side ? -len_s : len_s) - {dsa[rcp_pkg::DS_W-1], dsa};
                    mstep_next = 4'd0;
                    sat_next   = 1'b0;
                    sq_next    = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                case (mstep_reg)
                    4'd1:    lim_next = prod_reg;
                    4'd2:    t1_next = {prod_reg[rcp_pkg::PROD_W-1], prod_reg};
                    4'd3:    t1_next = t1_reg + {prod_reg[rcp_pkg::PROD_W-1], prod_reg};
                    4'd4:    t2_next = {prod_reg[rcp_pkg::PROD_W-1], prod_reg};
                    4'd5:    t2_next = t2_reg + {prod_reg[rcp_pkg::PROD_W-1], prod_reg};
                    4'd6:    num_next[0] = prod_reg;
                    4'd7:    num_next[1] = prod_reg;
                    4'd8:    num_next[2] = prod_reg;
                    default: lim_next = lim_reg;
                endcase
                mstep_next = mstep_reg + 4'd1;
                if (mstep_reg == 4'd8)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                mstep_next = 4'd0;
                k_next     = 2'd0;
                if ((t1_abs < lim_reg) && (t2_abs < lim_reg))
                begin
                    state_next = ST_DIVSAT;
                end
                else
                begin
                    state_next = ST_FACE;
                end
            end
            ST_DIVSAT:
            begin
                // A quotient of 2^25 or more saturates the distance outright.
                if (num_abs >= {2'b0, den, 25'b0})
                begin
                    sat_next = 1'b1;
                    if (k_reg == 2'd2)
                    begin
                        state_next = ST_RESULT;
                    end
                    else
                    begin
                        k_next = k_reg + 2'd1;
                    end
                end
                else
                begin
                    rem_next   = num_abs;
                    dsh_next   = {3'b0, den, 24'b0};
                    q_next     = '0;
                    iter_next  = 5'd24;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (rem_reg >= dsh_reg)
                begin
                    rem_next = rem_reg - dsh_reg;
                    q_next   = {q_reg[rcp_pkg::Q_W-2:0], 1'b1};
                end
                else
                begin
                    q_next = {q_reg[rcp_pkg::Q_W-2:0], 1'b0};
                end
                dsh_next  = dsh_reg >> 1;
                iter_next = iter_reg - 5'd1;
                if (iter_reg == 5'd0)
                begin
                    state_next = ST_SQMUL;
                end
            end
            ST_SQMUL:
            begin
                state_next = ST_SQADD;
            end
            ST_SQADD:
            begin
                sq_next = sq_reg + prod_reg[rcp_pkg::SQ_W-1:0];
                if (k_reg == 2'd2)
                begin
                    if (sat_reg)
                    begin
                        state_next = ST_RESULT;
                    end
                    else
                    begin
                        v_next     = sq_reg + prod_reg[rcp_pkg::SQ_W-1:0];
                        r_next     = '0;
                        b_next     = {2'b01, 50'b0};
                        iter_next  = 5'd25;
                        state_next = ST_SQRT;
                    end
                end
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = ST_DIVSAT;
                end
            end
            ST_SQRT:
            begin
                if (v_reg >= rb_sum)
                begin
                    v_next = v_reg - rb_sum;
                    r_next = (r_reg >> 1) + b_reg;
                end
                else
                begin
                    r_next = r_reg >> 1;
                end
                b_next    = b_reg >> 2;
                iter_next = iter_reg - 5'd1;
                if (iter_reg == 5'd0)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (!chit_reg || (face_d < cbest_reg))
                begin
                    cbest_next = face_d;
                end
                chit_next  = 1'b1;
                state_next = ST_FACE;
            end
            ST_FACE:
            begin
                if (face_reg == 3'd5)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    face_next  = face_reg + 3'd1;
                    state_next = ST_SETUP;
                end
            end
            ST_DONE:
            begin
                if (!cube_reg.last)
                begin
                    any_next   = upd_any;
                    bidx_next  = upd_idx;
                    best_next  = upd_best;
                    cnt_next   = cnt_ok ? cnt_reg + CNT_W'(1) : cnt_reg;
                    state_next = ST_IDLE;
                end
                else if (res_ready)
                begin
                    any_next   = 1'b0;
                    bidx_next  = '0;
                    best_next  = rcp_pkg::DIST_MAX;
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            best_reg  <= rcp_pkg::DIST_MAX;
            bidx_reg  <= '0;
            any_reg   <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            best_reg  <= best_next;
            bidx_reg  <= bidx_next;
            any_reg   <= any_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        face_reg  <= face_next;
        mstep_reg <= mstep_next;
        k_reg     <= k_next;
        iter_reg  <= iter_next;
        ux_reg    <= ux_next;
        uy_reg    <= uy_next;
        uz_reg    <= uz_next;
        cube_reg  <= cube_next;
        n_reg     <= n_next;
        prod_reg  <= ma * mb;
        lim_reg   <= lim_next;
        t1_reg    <= t1_next;
        t2_reg    <= t2_next;
        num_reg   <= num_next;
        sat_reg   <= sat_next;
        sq_reg    <= sq_next;
        rem_reg   <= rem_next;
        dsh_reg   <= dsh_next;
        q_reg     <= q_next;
        v_reg     <= v_next;
        r_reg     <= r_next;
        b_reg     <= b_next;
        chit_reg  <= chit_next;
        cbest_reg <= cbest_next;
    end

endmodule
`default_nettype wire

>>> tb/pick_checker.sv
// Checker for ray_cube_pick_nearest: watches the configuration, cube and result
// channels, predicts each pick result and compares it. Depends on rcp_pkg.
`default_nettype none
module pick_checker (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write,
    input  wire logic [rcp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [rcp_pkg::COORD_W-1:0]         cfg_data,
    input  wire logic                                push,
    input  wire logic                                full,
    input  wire logic signed [rcp_pkg::COORD_W-1:0]  center_x,
    input  wire logic signed [rcp_pkg::COORD_W-1:0]  center_y,
    input  wire logic signed [rcp_pkg::COORD_W-1:0]  center_z,
    input  wire logic [rcp_pkg::LEN_W-1:0]           edge_length,
    input  wire logic                                last_cube,
    input  wire logic                                empty,
    input  wire logic                                pop,
    input  wire logic                                hit_found,
    input  wire logic [rcp_pkg::IDXO_W-1:0]          nearest_index,
    input  wire logic [rcp_pkg::DIST_W-1:0]          nearest_distance,
    output int                                       errors,
    output int                                       pending,
    output int                                       cubes_seen,
    output int                                       picks_done,
    output int                                       hits_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_CUBES = 64;
    localparam longint unsigned DMAX = longint'(rcp_pkg::DIST_MAX);

    longint     ray_s[3];
    longint     ray_e[3];
    longint unsigned best_dist;
    int         best_idx;
    bit         any_hit;
    int         cube_cnt;
    rcp_pkg::result_t awaited[$];

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint mag(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Nearest face hit of one cube along the whole line; zero means no hit.
    function automatic longint unsigned face_hit_distance(longint c[3], longint len);
        longint u[3];
        longint plane, num, lim, t, dk;
        longint unsigned best, sq, d, m;
        bit hit, in_bounds, sat;
        best = 0;
        hit = 0;
        for (int k = 0; k < 3; k++)
            u[k] = ray_e[k] - ray_s[k];
        for (int a = 0; a < 3; a++)
        begin
            if (u[a] == 0)
                continue;
            for (int side = 0; side < 2; side++)
            begin
                plane = 2 * c[a] + ((side == 0) ? len : -len);
                num = plane - 2 * ray_s[a];
                lim = len * mag(u[a]);
                in_bounds = (len > 0);
                for (int k = 0; k < 3; k++)
                begin
                    if (k == a)
                        continue;
                    t = (2 * ray_s[k] - 2 * c[k]) * u[a] + u[k] * num;
                    if (!(mag(t) < lim))
                        in_bounds = 0;
                end
                if (!in_bounds)
                    continue;
                sq = 0;
                sat = 0;
                for (int k = 0; k < 3; k++)
                begin
                    dk = (u[k] * num) / (2 * u[a]);
                    m = longint'(mag(dk));
                    if (m > DMAX)
                        sat = 1;
                    else
                        sq += m * m;
                end
                d = sat ? DMAX : floor_sqrt(sq);
                if (d > DMAX)
                    d = DMAX;
                if (!hit || d < best)
                    best = d;
                hit = 1;
            end
        end
        return hit ? best : 0;
    endfunction

    function automatic void clear_pick();
        best_dist = DMAX;
        best_idx = 0;
        any_hit = 0;
        cube_cnt = 0;
    endfunction

    assign pending = awaited.size();

    always @(posedge clk or negedge rst_n)
    begin
        longint c[3];
        longint unsigned d;
        rcp_pkg::result_t exp_r;
        rcp_pkg::result_t got;
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                ray_s[k] = 0;
                ray_e[k] = 0;
            end
            clear_pick();
            awaited.delete();
            errors = 0;
            cubes_seen = 0;
            picks_done = 0;
            hits_seen = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    rcp_pkg::CFG_START_X: ray_s[0] = longint'($signed(cfg_data));
                    rcp_pkg::CFG_START_Y: ray_s[1] = longint'($signed(cfg_data));
                    rcp_pkg::CFG_START_Z: ray_s[2] = longint'($signed(cfg_data));
                    rcp_pkg::CFG_END_X:   ray_e[0] = longint'($signed(cfg_data));
                    rcp_pkg::CFG_END_Y:   ray_e[1] = longint'($signed(cfg_data));
                    rcp_pkg::CFG_END_Z:   ray_e[2] = longint'($signed(cfg_data));
                    default: ;
                endcase
            end

            if (push && !full)
            begin
                cubes_seen++;
                c[0] = longint'(center_x);
                c[1] = longint'(center_y);
                c[2] = longint'(center_z);
                if (cube_cnt < MAX_CUBES)
                begin
                    d = face_hit_distance(c, longint'(edge_length));
                    if (d > 0 && (!any_hit || d < best_dist))
                    begin
                        best_dist = d;
                        best_idx = cube_cnt;
                        any_hit = 1;
                    end
                    cube_cnt++;
                end
                if (last_cube)
                begin
                    exp_r.hit = any_hit;
                    exp_r.index = any_hit ? best_idx[rcp_pkg::IDXO_W-1:0] : '0;
                    exp_r.distance = any_hit ? best_dist[rcp_pkg::DIST_W-1:0] : '0;
                    awaited = {awaited, exp_r};
                    clear_pick();
                end
            end

            if (pop && !empty)
            begin
                got.hit = hit_found;
                got.index = nearest_index;
                got.distance = nearest_distance;
                if (awaited.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: unexpected result hit=%0b index=%0d dist=%0d",
                                 $realtime, got.hit, got.index, got.distance);
                end
                else
                begin
                    exp_r = awaited.pop_front();
                    picks_done++;
                    if (exp_r.hit)
                        hits_seen++;
                    if (got !== exp_r)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("%0t: result mismatch: expected hit=%0b index=%0d dist=%0d",
                                     $realtime, exp_r.hit, exp_r.index, exp_r.distance);
                            $display("    got hit=%0b index=%0d dist=%0d",
                                     got.hit, got.index, got.distance);
                        end
                    end
                end
            end
        end
    end

endmodule
`default_nettype wire

>>> tb/testbench.sv
// Top of the ray_cube_pick_nearest testbench: clock, reset, ray configuration and
// cube stimulus, result draining and the verdict. Depends on rcp_pkg and pick_checker.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // How long we let the block settle after the results before the ray is rewritten.
    localparam int SETTLE_CYCLES = 1000;
    localparam int TARGET_CUBES = 700;

    logic                                clk;
    logic                                rst_n;
    logic                                cfg_write;
    logic [rcp_pkg::CFG_IDX_W-1:0]       cfg_index;
    logic [rcp_pkg::COORD_W-1:0]         cfg_data;
    logic                                push;
    logic                                full;
    logic signed [rcp_pkg::COORD_W-1:0]  center_x;
    logic signed [rcp_pkg::COORD_W-1:0]  center_y;
    logic signed [rcp_pkg::COORD_W-1:0]  center_z;
    logic [rcp_pkg::LEN_W-1:0]           edge_length;
    logic                                last_cube;
    logic                                empty;
    logic                                pop;
    logic                                hit_found;
    logic [rcp_pkg::IDXO_W-1:0]          nearest_index;
    logic [rcp_pkg::DIST_W-1:0]          nearest_distance;

    int errors, pending, cubes_seen, picks_done, hits_seen;

    // no_gaps and hold_request are shared with the draining process; the rest is stimulus state.
    bit     no_gaps;
    bit     hold_request;
    int     cubes_sent;
    longint ray_s[3];
    longint ray_e[3];

    ray_cube_pick_nearest u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .push(push), .full(full),
        .center_x(center_x), .center_y(center_y), .center_z(center_z),
        .edge_length(edge_length), .last_cube(last_cube),
        .empty(empty), .pop(pop),
        .hit_found(hit_found), .nearest_index(nearest_index),
        .nearest_distance(nearest_distance)
    );

    pick_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .push(push), .full(full),
        .center_x(center_x), .center_y(center_y), .center_z(center_z),
        .edge_length(edge_length), .last_cube(last_cube),
        .empty(empty), .pop(pop),
        .hit_found(hit_found), .nearest_index(nearest_index),
        .nearest_distance(nearest_distance),
        .errors(errors), .pending(pending), .cubes_seen(cubes_seen),
        .picks_done(picks_done), .hits_seen(hits_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard limit on the simulated time.
    initial
    begin
        #100ms;
        $display("Timeout with %0d results still awaited", pending);
        $display("Regression FAIL");
        $finish;
    end

    // Coordinates are clipped to the signed 24-bit range of the ports.
    function automatic logic [rcp_pkg::COORD_W-1:0] clip_coord(longint v);
        if (v > 64'sd8388607)
            return 24'h7FFFFF;
        if (v < -64'sd8388608)
            return 24'h800000;
        return v[rcp_pkg::COORD_W-1:0];
    endfunction

    // Writes one ray register and leaves the enable high; set_ray lowers it
    // after its last write.
    task automatic write_reg(logic [rcp_pkg::CFG_IDX_W-1:0] idx, longint value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= clip_coord(value);
        @(posedge clk);
    endtask

    task automatic set_ray(longint sx, longint sy, longint sz,
                           longint ex, longint ey, longint ez);
        ray_s[0] = longint'($signed(clip_coord(sx)));
        ray_s[1] = longint'($signed(clip_coord(sy)));
        ray_s[2] = longint'($signed(clip_coord(sz)));
        ray_e[0] = longint'($signed(clip_coord(ex)));
        ray_e[1] = longint'($signed(clip_coord(ey)));
        ray_e[2] = longint'($signed(clip_coord(ez)));
        write_reg(rcp_pkg::CFG_START_X, sx);
        write_reg(rcp_pkg::CFG_START_Y, sy);
        write_reg(rcp_pkg::CFG_START_Z, sz);
        write_reg(rcp_pkg::CFG_END_X, ex);
        write_reg(rcp_pkg::CFG_END_Y, ey);
        write_reg(rcp_pkg::CFG_END_Z, ez);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // Waits until every awaited result has been popped, then lets any cube
    // that produces no result drain from the block.
    task automatic wait_quiet();
        push <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Offers one cube and returns at the edge on which it was taken.
    task automatic send_cube(longint cx, longint cy, longint cz, longint len, bit last);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        center_x <= clip_coord(cx);
        center_y <= clip_coord(cy);
        center_z <= clip_coord(cz);
        edge_length <= (len > 64'sd8388607) ? 23'h7FFFFF : len[rcp_pkg::LEN_W-1:0];
        last_cube <= last;
        do
            @(posedge clk);
        while (full);
        cubes_sent++;
    endtask

    // Fully random cube: every bit of every field gets exercised here.
    task automatic send_noise_cube(bit last);
        send_cube(longint'($signed(24'($urandom))), longint'($signed(24'($urandom))),
                  longint'($signed(24'($urandom))), longint'($urandom_range(0, 23'h7FFFFF)),
                  last);
    endtask

    // Cube placed close to the ray line, between one ray length behind the start and one
    // ray length past the end point, so that a good share are hit.
    task automatic send_near_cube(bit last);
        longint t, len, p[3];
        t = longint'($urandom_range(0, 96)) - 32;
        for (int k = 0; k < 3; k++)
            p[k] = ray_s[k] + ((ray_e[k] - ray_s[k]) * t) / 32
                   + longint'($urandom_range(0, 512)) - 256;
        case ($urandom_range(0, 9))
            0:       len = 0;
            1:       len = $urandom_range(1, 23'h7FFFFF);
            2, 3:    len = $urandom_range(1, 64);
            default: len = $urandom_range(256, 8192);
        endcase
        send_cube(p[0], p[1], p[2], len, last);
    endtask

    task automatic random_ray();
        longint v[6];
        int style;
        style = $urandom_range(0, 5);
        for (int k = 0; k < 6; k++)
        begin
            case (style)
                0, 1:    v[k] = longint'($signed(24'($urandom)));
                default: v[k] = longint'($urandom_range(0, 8192)) - 4096;
            endcase
        end
        // Axis-aligned rays leave one or two axes without a ray component.
        if (style == 2)
            v[4] = v[1];
        if (style == 3)
        begin
            v[3] = v[0];
            v[5] = v[2];
        end
        set_ray(v[0], v[1], v[2], v[3], v[4], v[5]);
    endtask

    // Draining side: random stalls between results, and one long hold-off on
    // request so that the block's queue fills and it refuses cubes.
    initial
    begin
        int stall;
        stall = 0;
        pop <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
                stall = no_gaps ? 0 : $urandom_range(0, 16);
            if (hold_request)
            begin
                hold_request = 0;
                pop <= 1'b0;
                repeat (2000) @(posedge clk);
                pop <= 1'b1;
            end
            else if (stall > 0)
            begin
                pop <= 1'b0;
                stall--;
            end
            else
                pop <= 1'b1;
        end
    end

    initial
    begin
        int phase;
        int pick_len;
        rst_n <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        push <= 1'b0;
        center_x <= '0;
        center_y <= '0;
        center_z <= '0;
        edge_length <= '0;
        last_cube <= 1'b0;
        no_gaps = 0;
        hold_request = 0;
        cubes_sent = 0;
        for (int k = 0; k < 3; k++)
        begin
            ray_s[k] = 0;
            ray_e[k] = 0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // With the ray left at reset the start equals the end: nothing is hit.
        send_cube(0, 0, 0, 512, 1'b1);
        wait_quiet();

        // Ray along x from the origin.
        set_ray(0, 0, 0, 256, 0, 0);
        // Start inside the cube: faces at x = +/-256 are both 256 away.
        send_cube(0, 0, 0, 512, 1'b0);
        // Zero edge length never hits; a cube off the line misses.
        send_cube(0, 0, 0, 0, 1'b0);
        send_cube(0, 5000, 0, 512, 1'b0);
        // Cube behind the start still counts, the line runs both ways.
        send_cube(-1000, 0, 0, 100, 1'b1);
        // A face through the start gives zero distance: a miss for that cube.
        send_cube(256, 0, 0, 512, 1'b1);
        // Ties keep the earlier cube.
        send_cube(3000, 0, 0, 200, 1'b0);
        send_cube(3000, 0, 0, 200, 1'b1);
        // Largest and smallest coordinates and the widest edge.
        send_cube(8388607, 0, 0, 8388607, 1'b0);
        send_cube(-8388608, 8388607, -8388608, 8388607, 1'b1);
        wait_quiet();

        // Extreme ray: each ray component is as large as its width allows.
        set_ray(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607);
        send_cube(8388607, 8388607, 8388607, 8388607, 1'b0);
        send_cube(-8388608, -8388608, -8388608, 1, 1'b0);
        send_cube(0, 0, 0, 8388607, 1'b1);
        send_cube(8388000, 8388000, 8388000, 256, 1'b1);
        wait_quiet();

        // Diagonal ray, then a pick longer than the cube limit.
        set_ray(0, 0, 0, 256, 256, 256);
        for (int i = 0; i < 70; i++)
        begin
            if (i == 66)
                send_cube(0, 0, 0, 100, 1'b0);
            else
                send_near_cube(i == 69);
        end
        wait_quiet();

        phase = 0;
        while (cubes_sent < TARGET_CUBES)
        begin
            random_ray();
            no_gaps = ($urandom_range(0, 3) == 0);
            if (phase == 1)
            begin
                // Results pile up while the receiver holds off.
                hold_request = 1;
                for (int i = 0; i < 12; i++)
                    send_near_cube(1'b1);
            end
            for (int p = 0; p < 6; p++)
            begin
                pick_len = $urandom_range(1, 6);
                for (int i = 0; i < pick_len; i++)
                begin
                    if ($urandom_range(0, 6) == 0)
                        send_noise_cube(i == pick_len - 1);
                    else
                        send_near_cube(i == pick_len - 1);
                end
                // Now and then the sender waits for every result mid-phase.
                if ($urandom_range(0, 9) == 0)
                begin
                    push <= 1'b0;
                    while (pending != 0)
                        @(posedge clk);
                end
            end
            wait_quiet();
            phase++;
        end

        no_gaps = 0;
        push <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Ran %0d cubes over %0d picks, %0d of them with a hit, across %0d rays.",
                 cubes_seen, picks_done, hits_seen, phase + 3);
        if (errors == 0)
            $display("Regression PASS");
        else
        begin
            $display("%0d mismatches", errors);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
`default_nettype wire
